### hdl/sdz_pkg.sv
// Shared types and constants for the smoothed distance zone bar.
package sdz_pkg;

    localparam int DIST_W     = 13;
    localparam int SCALE_W    = 8;
    localparam int ZONE_W     = 3;
    localparam int LIT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [ZONE_W-1:0] ZONE_NONE   = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_CLOSE  = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_STOP   = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_YELLOW = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_GREEN  = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_FAR    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YELLOW_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_PIXEL = 3'd4;

    localparam logic [DIST_W-1:0]  RST_MIN_OFFSET   = 13'd100;
    localparam logic [DIST_W-1:0]  RST_STOP_LIMIT   = 13'd300;
    localparam logic [DIST_W-1:0]  RST_YELLOW_LIMIT = 13'd600;
    localparam logic [DIST_W-1:0]  RST_GREEN_LIMIT  = 13'd900;
    localparam logic [SCALE_W-1:0] RST_MM_PER_PIXEL = 8'd10;
    localparam logic [SCALE_W-1:0] DEFAULT_SCALE    = 8'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV_AVG,
        ST_ZONE,
        ST_DIV_LIT,
        ST_FIN
    } state_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic                start;
        logic [SCALE_W-1:0]  divisor;
    } div_req_t;

endpackage

### hdl/sdz_if.sv
// Channel interfaces: distance samples, results and configuration writes.
interface sdz_sample_if;
    logic                       valid;
    logic                       ready;
    logic [sdz_pkg::DIST_W-1:0] distance_mm;
    logic                       reading_ok;

    modport source (output valid, output distance_mm, output reading_ok, input ready);
    modport sink   (input valid, input distance_mm, input reading_ok, output ready);
endinterface

interface sdz_result_if;
    logic                       valid;
    logic                       ready;
    logic [sdz_pkg::DIST_W-1:0] average_mm;
    logic [sdz_pkg::ZONE_W-1:0] zone;
    logic [sdz_pkg::LIT_W-1:0]  lit_count;

    modport source (output valid, output average_mm, output zone, output lit_count, input ready);
    modport sink   (input valid, input average_mm, input zone, input lit_count, output ready);
endinterface

interface sdz_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sdz_pkg::CFG_IDX_W-1:0]  index;
    logic [sdz_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/sdz_div.sv
// Restoring divider, one quotient bit per cycle, used for the bar count.
module sdz_div #(
    parameter int DW = 18
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sdz_pkg::div_req_t               req,
    input  logic [DW-1:0]                   dividend,
    output logic                            busy,
    output logic                            done,
    output logic [DW-1:0]                   quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]                  quo_reg, quo_next;
    logic [sdz_pkg::SCALE_W-1:0]    rem_reg, rem_next;
    logic [sdz_pkg::SCALE_W-1:0]    dvs_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [sdz_pkg::SCALE_W:0]      trial;
    logic [sdz_pkg::SCALE_W:0]      diff;
    logic                           fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = fits ? diff[sdz_pkg::SCALE_W-1:0] : trial[sdz_pkg::SCALE_W-1:0];
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

### hdl/smoothed_distance_zone_bar.sv
// Top level: moving average of distance readings, zone decision and bar length.
//
// Channels: sample (distance_mm, reading_ok) in, result (average_mm, zone,
// lit_count) out, cfg writes the five registers by index (0 min offset,
// 1 stop limit, 2 yellow limit, 3 green limit, 4 mm per pixel); cfg.ready
// is always high and an index past the list is dropped.
// Every request gives exactly one result. A reading with reading_ok low
// returns zone 0 with zeros and leaves the history alone; a valid one
// replaces the oldest of WINDOW samples and returns the truncated average.
// An invalid reading goes straight to the finish step; a valid one reads
// the history, averages and picks the zone, and, in yellow and green, also
// computes the bar. The average comes from a reciprocal multiply; the bar
// count takes a pass of the bit-serial divider. sample.ready is high only
// when idle, so a request is taken only once the previous one is finished.
// The result sits in an output register, so the next request can be taken
// while the receiver stalls; finishing it then waits for that register.
// Reset restores the register defaults, zeroes the history (per-entry
// valid bits) and clears the running sum; no clearing pass is needed.
module smoothed_distance_zone_bar #(
    parameter int WINDOW = 20,
    parameter int PIXELS = 30
) (
    input  logic            clk,
    input  logic            rst_n,
    sdz_sample_if.sink      sample,
    sdz_result_if.source    result,
    sdz_cfg_if.sink         cfg
);

    localparam int DW     = sdz_pkg::DIST_W;
    localparam int SUM_W  = $clog2(WINDOW * ((1 << sdz_pkg::DIST_W) - 1) + 1);
    localparam int PW     = $clog2(WINDOW);
    localparam int NW     = DW + 1;
    localparam int RW     = SUM_W + 1;
    localparam int AVG_SH = SUM_W + PW;
    localparam int PROD_W = SUM_W + RW;
    // ceil(2^AVG_SH / WINDOW): exact truncated quotient for any running sum
    localparam logic [RW-1:0] AVG_RECIP =
        RW'(((longint'(1) << AVG_SH) + longint'(WINDOW) - longint'(1)) / longint'(WINDOW));

    // configuration
    logic [DW-1:0]               min_offset_reg;
    logic [DW-1:0]               stop_limit_reg;
    logic [DW-1:0]               yellow_limit_reg;
    logic [DW-1:0]               green_limit_reg;
    logic [sdz_pkg::SCALE_W-1:0] mm_per_pixel_reg;

    // history
    logic [DW-1:0]               ring_mem [WINDOW];
    logic [DW-1:0]               rd_data_reg;
    logic [WINDOW-1:0]           filled_reg;
    logic [PW-1:0]               pos_reg;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [DW-1:0]               oldest;

    // work registers
    sdz_pkg::state_t             state_reg, state_next;
    logic [DW-1:0]               dist_reg;
    logic [DW-1:0]               avg_reg;
    logic [sdz_pkg::ZONE_W-1:0]  zone_reg, zone_sel;
    logic [sdz_pkg::LIT_W-1:0]   lit_reg, lit_calc;
    logic [DW-1:0]               limit_reg, limit_sel;

    // output register
    logic                        out_valid_reg;
    logic [DW-1:0]               out_avg_reg;
    logic [sdz_pkg::ZONE_W-1:0]  out_zone_reg;
    logic [sdz_pkg::LIT_W-1:0]   out_lit_reg;

    // control
    logic                        sample_take;
    logic                        out_free;
    logic                        load_out;
    sdz_pkg::div_req_t           div_req;
    logic [DW-1:0]               div_dividend;
    logic                        div_busy;
    logic                        div_done;
    logic [DW-1:0]               div_quo;
    logic [sdz_pkg::SCALE_W-1:0] scale;
    logic [NW-1:0]               bar_n;
    logic [PROD_W-1:0]           avg_prod;
    logic [DW-1:0]               avg_calc;

    assign cfg.ready   = 1'b1;
    assign out_free    = !out_valid_reg || result.ready;
    assign sample_take = sample.valid && sample.ready;
    assign oldest      = filled_reg[pos_reg] ? rd_data_reg : '0;
    assign sum_next    = sum_reg - SUM_W'(oldest) + SUM_W'(dist_reg);
    assign scale       = (mm_per_pixel_reg == '0) ? sdz_pkg::DEFAULT_SCALE : mm_per_pixel_reg;
    assign avg_prod    = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);
    assign avg_calc    = avg_prod[AVG_SH +: DW];

    // first test that holds decides, whatever order the limits are in
    always_comb
    begin
        limit_sel = green_limit_reg;
        priority if (avg_reg < min_offset_reg)
            zone_sel = sdz_pkg::ZONE_CLOSE;
        else if (avg_reg < stop_limit_reg)
            zone_sel = sdz_pkg::ZONE_STOP;
        else if (avg_reg < yellow_limit_reg)
        begin
            zone_sel  = sdz_pkg::ZONE_YELLOW;
            limit_sel = yellow_limit_reg;
        end
        else if (avg_reg < green_limit_reg)
            zone_sel = sdz_pkg::ZONE_GREEN;
        else
            zone_sel = sdz_pkg::ZONE_FAR;
    end

    // bar length: quotient + 1, clamped to the strip, low five bits kept
    always_comb
    begin
        bar_n = {1'b0, div_quo} + NW'(1);
        if (bar_n > NW'(PIXELS))
            bar_n = NW'(PIXELS);
        lit_calc = bar_n[sdz_pkg::LIT_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdz_pkg::ST_IDLE:
                if (sample.valid)
                    state_next = sample.reading_ok ? sdz_pkg::ST_READ : sdz_pkg::ST_FIN;
            sdz_pkg::ST_READ:
                state_next = sdz_pkg::ST_DIV_AVG;
            sdz_pkg::ST_DIV_AVG:
                state_next = sdz_pkg::ST_ZONE;
            sdz_pkg::ST_ZONE:
                if (zone_sel == sdz_pkg::ZONE_YELLOW || zone_sel == sdz_pkg::ZONE_GREEN)
                    state_next = sdz_pkg::ST_DIV_LIT;
                else
                    state_next = sdz_pkg::ST_FIN;
            sdz_pkg::ST_DIV_LIT:
                if (div_done)
                    state_next = sdz_pkg::ST_FIN;
            sdz_pkg::ST_FIN:
                if (out_free)
                    state_next = sdz_pkg::ST_IDLE;
            default:
                state_next = sdz_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample.ready    = 1'b0;
        load_out        = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = scale;
        div_dividend    = limit_sel - avg_reg;
        unique case (state_reg)
            sdz_pkg::ST_IDLE:
                sample.ready = 1'b1;
            sdz_pkg::ST_ZONE:
                div_req.start = (zone_sel == sdz_pkg::ZONE_YELLOW)
                             || (zone_sel == sdz_pkg::ZONE_GREEN);
            sdz_pkg::ST_FIN:
                load_out = out_free;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sdz_pkg::ST_IDLE;
            min_offset_reg   <= sdz_pkg::RST_MIN_OFFSET;
            stop_limit_reg   <= sdz_pkg::RST_STOP_LIMIT;
            yellow_limit_reg <= sdz_pkg::RST_YELLOW_LIMIT;
            green_limit_reg  <= sdz_pkg::RST_GREEN_LIMIT;
            mm_per_pixel_reg <= sdz_pkg::RST_MM_PER_PIXEL;
            filled_reg       <= '0;
            pos_reg          <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    sdz_pkg::REG_MIN_OFFSET:   min_offset_reg   <= cfg.data;
                    sdz_pkg::REG_STOP_LIMIT:   stop_limit_reg   <= cfg.data;
                    sdz_pkg::REG_YELLOW_LIMIT: yellow_limit_reg <= cfg.data;
                    sdz_pkg::REG_GREEN_LIMIT:  green_limit_reg  <= cfg.data;
                    sdz_pkg::REG_MM_PER_PIXEL: mm_per_pixel_reg <= cfg.data[sdz_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == sdz_pkg::ST_READ)
            begin
                sum_reg             <= sum_next;
                filled_reg[pos_reg] <= 1'b1;
                pos_reg             <= (pos_reg == PW'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // history memory and payload registers
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring_mem[pos_reg];
        if (state_reg == sdz_pkg::ST_READ)
            ring_mem[pos_reg] <= dist_reg;
        if (sample_take)
        begin
            dist_reg <= sample.distance_mm;
            avg_reg  <= '0;
            zone_reg <= sdz_pkg::ZONE_NONE;
            lit_reg  <= '0;
        end
        if (state_reg == sdz_pkg::ST_DIV_AVG)
            avg_reg <= avg_calc;
        if (state_reg == sdz_pkg::ST_ZONE)
        begin
            zone_reg  <= zone_sel;
            limit_reg <= limit_sel;
        end
        if (state_reg == sdz_pkg::ST_DIV_LIT && div_done)
            lit_reg <= lit_calc;
        if (load_out)
        begin
            out_avg_reg  <= avg_reg;
            out_zone_reg <= zone_reg;
            out_lit_reg  <= lit_reg;
        end
    end

    sdz_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result.valid      = out_valid_reg;
    assign result.average_mm = out_avg_reg;
    assign result.zone       = out_zone_reg;
    assign result.lit_count  = out_lit_reg;

`ifndef SYNTHESIS
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_busy)
        else $error("division started while the divider is busy");
    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("finished result not presented");
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_W'(WINDOW * ((1 << sdz_pkg::DIST_W) - 1)))
        else $error("running sum exceeds the window capacity");
    a_lit_zone: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.lit_count != '0)
            |-> (result.zone == sdz_pkg::ZONE_YELLOW || result.zone == sdz_pkg::ZONE_GREEN))
        else $error("lit pixels outside the yellow and green zones");
    a_limit_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdz_pkg::ST_DIV_LIT) |-> (limit_reg >= avg_reg))
        else $error("bar limit below the average");
`endif

endmodule
